### sv/lsc_pkg.sv
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared types and constants of the line splitter with length cap.
// ----------------------------------------------------------------------------
package lsc_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int LEN_BITS       = 16;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [7:0] LF_BYTE = 8'h0A;
    localparam logic [7:0] CR_BYTE = 8'h0D;

    localparam logic [1:0] WR_NONE = 2'd0;
    localparam logic [1:0] WR_ONE  = 2'd1;
    localparam logic [1:0] WR_TWO  = 2'd2;

    typedef struct packed {
        logic [7:0] line_data;
        logic       has_data;
        logic       line_end;
        logic       truncated;
    } t_result;

    typedef struct packed {
        logic [1:0] num;
        t_result    res0;
        t_result    res1;
    } t_qwrite;

endpackage

### sv/lsc_front.sv
// ----------------------------------------------------------------------------
// lsc_front
// Classifies each accepted byte and produces up to two results per byte.
// ----------------------------------------------------------------------------
module lsc_front
    import lsc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_in_byte,
    input  logic [LEN_BITS-1:0] i_max_line,
    output t_qwrite             o_wr
);

    logic                  r_discarding, n_discarding;
    logic                  r_pending_cr, n_pending_cr;
    logic [COUNT_BITS-1:0] r_line_count, n_line_count;
    logic [LEN_BITS-1:0]   r_line_len, n_line_len;

    t_result cr_res, b_res;
    logic    cr_vld, b_vld, close;

    always_comb begin
        n_discarding = r_discarding;
        n_pending_cr = r_pending_cr;
        n_line_len   = r_line_len;
        cr_vld       = 1'b0;
        b_vld        = 1'b0;
        close        = 1'b0;
        cr_res       = '{line_data: CR_BYTE, has_data: 1'b1, line_end: 1'b0, truncated: 1'b0};
        b_res        = '{line_data: i_in_byte, has_data: 1'b1, line_end: 1'b0,
                         truncated: 1'b0};
        if (r_discarding) begin
            if (i_in_byte == LF_BYTE) begin
                n_discarding = 1'b0;
                n_line_len   = '0;
                n_pending_cr = 1'b0;
            end
        end else if (i_in_byte == LF_BYTE) begin
            b_vld  = 1'b1;
            b_res  = '{line_data: 8'h00, has_data: 1'b0, line_end: 1'b1, truncated: 1'b0};
            close  = 1'b1;
        end else begin
            cr_vld       = r_pending_cr;
            n_pending_cr = 1'b0;
            if (i_max_line != '0 && r_line_len >= i_max_line) begin
                b_vld        = 1'b1;
                b_res        = '{line_data: 8'h00, has_data: 1'b0, line_end: 1'b1,
                                 truncated: 1'b1};
                close        = 1'b1;
                n_discarding = 1'b1;
            end else begin
                if (r_line_len != '1) begin
                    n_line_len = r_line_len + LEN_BITS'(1);
                end
                if (i_in_byte == CR_BYTE) begin
                    n_pending_cr = 1'b1;
                end else begin
                    b_vld = 1'b1;
                end
            end
        end
        n_line_count = r_line_count;
        if (close) begin
            n_line_len   = '0;
            n_pending_cr = 1'b0;
            if (r_line_count != '1) begin
                n_line_count = r_line_count + COUNT_BITS'(1);
            end
        end
    end

    always_comb begin
        o_wr.res0 = cr_vld ? cr_res : b_res;
        o_wr.res1 = b_res;
        if (!i_accept) begin
            o_wr.num = WR_NONE;
        end else if (cr_vld && b_vld) begin
            o_wr.num = WR_TWO;
        end else if (cr_vld || b_vld) begin
            o_wr.num = WR_ONE;
        end else begin
            o_wr.num = WR_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_discarding <= 1'b0;
            r_pending_cr <= 1'b0;
            r_line_count <= '0;
            r_line_len   <= '0;
        end else if (i_accept) begin
            r_discarding <= n_discarding;
            r_pending_cr <= n_pending_cr;
            r_line_count <= n_line_count;
            r_line_len   <= n_line_len;
        end
    end

endmodule

### sv/lsc_queue.sv
// ----------------------------------------------------------------------------
// lsc_queue
// Result queue that takes up to two results per cycle and delivers one.
// ----------------------------------------------------------------------------
module lsc_queue
    import lsc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_qwrite i_wr,
    input  logic    i_pop,
    output logic    o_full,
    output logic    o_empty,
    output t_result o_res
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    t_result               r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   r_wp, n_wp;
    logic [PTR_BITS-1:0]   r_rp, n_rp;
    logic [CNT_BITS-1:0]   r_count, n_count;
    logic                  rd;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count > CNT_BITS'(QUEUE_DEPTH - 2));
    assign o_res   = r_mem[r_rp];
    assign rd      = i_pop && !o_empty;

    always_comb begin
        n_wp    = r_wp + PTR_BITS'(i_wr.num);
        n_rp    = rd ? r_rp + PTR_BITS'(1) : r_rp;
        n_count = r_count + CNT_BITS'(i_wr.num) - CNT_BITS'(rd);
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.num != WR_NONE) begin
            r_mem[r_wp] <= i_wr.res0;
        end
        if (i_wr.num == WR_TWO) begin
            r_mem[r_wp + PTR_BITS'(1)] <= i_wr.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

endmodule

### sv/line_splitter_with_length_cap_core.sv
// ----------------------------------------------------------------------------
// line_splitter_with_length_cap_core
// Splits a byte stream into lines at LF with an optional length cap.
//
// Channel   Direction  Handshake       Payload
// input     in         push / full     i_in_byte
// result    out        empty / pop     o_line_data, o_has_data, o_line_end,
//                                      o_truncated
// config    in         i_cfg_we        i_cfg_wdata (max_line)
//
// One byte is accepted per cycle while full is low; its results enter the
// queue at the same edge and the oldest appears on the next cycle. A byte
// with two results needs two pops, so input stalls only while the
// four-entry queue holds three or more results. Reset is synchronous and
// clears framing state, the length cap and the queue.
// ----------------------------------------------------------------------------
module line_splitter_with_length_cap_core
    import lsc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [7:0]          i_in_byte,
    output logic                empty,
    input  logic                pop,
    output logic [7:0]          o_line_data,
    output logic                o_has_data,
    output logic                o_line_end,
    output logic                o_truncated,
    input  logic                i_cfg_we,
    input  logic [LEN_BITS-1:0] i_cfg_wdata
);

    logic [LEN_BITS-1:0] r_max_line;
    logic                accept;
    t_qwrite             wr;
    t_result             res;

    assign accept = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_line <= '0;
        end else if (i_cfg_we) begin
            r_max_line <= i_cfg_wdata;
        end
    end

    lsc_front #(
        .COUNT_BITS(COUNT_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_in_byte  (i_in_byte),
        .i_max_line (r_max_line),
        .o_wr       (wr)
    );

    lsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_res   (res)
    );

    assign o_line_data = res.line_data;
    assign o_has_data  = res.has_data;
    assign o_line_end  = res.line_end;
    assign o_truncated = res.truncated;

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the line splitter with length cap.
//
// Bytes are pushed into the block while its results are popped under a
// changing stall pattern. A predictor in this file frames the same byte
// stream into lines and keeps the expected results in order, and each
// popped transaction is compared field by field with the oldest of them.
// Directed tests cover plain lines, carriage return handling, the length
// cap and a cap change in the middle of a line.
// A long random test follows with a range of cap settings.
// ----------------------------------------------------------------------------
module tb_top;
    import lsc_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int TAIL_CYCLES = 8;
    localparam int RANDOM_ITEMS = 1600;

    typedef enum logic [1:0] {RX_STREAM, RX_COIN, RX_SPARSE, RX_BURSTY} t_rx_mode;

    logic                i_clk;
    logic                i_rst_n;
    logic                push;
    logic                full;
    logic [7:0]          i_in_byte;
    logic                empty;
    logic                pop;
    logic [7:0]          o_line_data;
    logic                o_has_data;
    logic                o_line_end;
    logic                o_truncated;
    logic                i_cfg_we;
    logic [LEN_BITS-1:0] i_cfg_wdata;

    logic [15:0] cap;
    logic        in_discard;
    logic        cr_held;
    logic [15:0] cur_len;

    t_result  line_items_q[$];
    t_result  want;
    t_rx_mode rx_mode;
    logic [5:0] rx_phase;
    int       n_cycles;
    int       n_errors;
    int       n_bytes_sent;
    int       n_results_checked;
    int       n_cap_settings;

    line_splitter_with_length_cap_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_byte   (i_in_byte),
        .empty       (empty),
        .pop         (pop),
        .o_line_data (o_line_data),
        .o_has_data  (o_has_data),
        .o_line_end  (o_line_end),
        .o_truncated (o_truncated),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_result make_result(input logic [7:0] data, input logic has,
                                            input logic fin, input logic trunc);
        t_result r;
        r.line_data = data;
        r.has_data  = has;
        r.line_end  = fin;
        r.truncated = trunc;
        return r;
    endfunction

    function automatic void frame_byte(input logic [7:0] b);
        if (in_discard) begin
            if (b == LF_BYTE) begin
                in_discard = 1'b0;
                cur_len    = '0;
                cr_held    = 1'b0;
            end
            return;
        end
        if (b == LF_BYTE) begin
            line_items_q.push_back(make_result(8'h00, 1'b0, 1'b1, 1'b0));
            cur_len = '0;
            cr_held = 1'b0;
            return;
        end
        if (cr_held) begin
            line_items_q.push_back(make_result(CR_BYTE, 1'b1, 1'b0, 1'b0));
            cr_held = 1'b0;
        end
        if (cap != 16'd0 && cur_len >= cap) begin
            line_items_q.push_back(make_result(8'h00, 1'b0, 1'b1, 1'b1));
            cur_len    = '0;
            cr_held    = 1'b0;
            in_discard = 1'b1;
            return;
        end
        if (cur_len != 16'hFFFF) begin
            cur_len = cur_len + 16'd1;
        end
        if (b == CR_BYTE) begin
            cr_held = 1'b1;
        end else begin
            line_items_q.push_back(make_result(b, 1'b1, 1'b0, 1'b0));
        end
    endfunction

    always @(negedge i_clk) begin
        rx_phase <= rx_phase + 6'd1;
        if (rx_phase == 6'd0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
        end
        case (rx_mode)
            RX_STREAM: pop <= 1'b1;
            RX_COIN:   pop <= 1'($urandom_range(0, 1));
            RX_SPARSE: pop <= ($urandom_range(0, 3) == 0);
            default:   pop <= rx_phase[3];
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (line_items_q.size() == 0) begin
                $error("unexpected result: line_data %h has_data %b line_end %b truncated %b",
                       o_line_data, o_has_data, o_line_end, o_truncated);
                n_errors++;
            end else begin
                want = line_items_q.pop_front();
                n_results_checked++;
                if (o_line_data !== want.line_data) begin
                    $error("line_data: expected %h, actual %h", want.line_data, o_line_data);
                    n_errors++;
                end
                if (o_has_data !== want.has_data) begin
                    $error("has_data: expected %b, actual %b", want.has_data, o_has_data);
                    n_errors++;
                end
                if (o_line_end !== want.line_end) begin
                    $error("line_end: expected %b, actual %b", want.line_end, o_line_end);
                    n_errors++;
                end
                if (o_truncated !== want.truncated) begin
                    $error("truncated: expected %b, actual %b", want.truncated, o_truncated);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        @(negedge i_clk);
        push      <= 1'b1;
        i_in_byte <= b;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        n_bytes_sent++;
        frame_byte(b);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i]);
        end
    endtask

    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge i_clk);
            push      <= 1'b0;
            i_in_byte <= 8'($urandom);
        end
    endtask

    task automatic settle();
        idle_cycles(1);
        while (line_items_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_max_line(input logic [15:0] v);
        settle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= 16'($urandom);
        cap = v;
        n_cap_settings++;
    endtask

    task automatic test_plain_lines();
        set_max_line(16'd0);
        send_text("A\n\n");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(LF_BYTE);
    endtask

    task automatic test_cr_handling();
        send_text("a\r\n");
        send_text("\r\rb\n");
        send_text("\r\r\n");
    endtask

    task automatic test_length_cap();
        set_max_line(16'd3);
        send_text("abcdef\n");
        send_text("ab\rX\n");
        send_text("abc\n");
        set_max_line(16'd1);
        send_text("\r\r\n");
    endtask

    task automatic test_cap_change_midline();
        set_max_line(16'd0);
        send_text("abcd");
        set_max_line(16'd2);
        send_text("f\n");
    endtask

    task automatic test_random_traffic();
        logic [15:0] caps[9];
        int          burst_left;
        int          line_max;
        int          line_len;
        int          sent;
        int          ending;
        caps = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd7, 16'd24, 16'hFFFF, 16'h8000, 16'd0};
        caps[8] = 16'($urandom_range(0, 65535));
        burst_left = 0;
        for (int p = 0; p < 9; p++) begin
            set_max_line(caps[p]);
            line_max = (cap == 16'd0 || cap > 16'd40) ? 40 : int'(cap) + 3;
            sent = 0;
            while (sent < RANDOM_ITEMS / 9) begin
                line_len = $urandom_range(0, line_max);
                ending   = $urandom_range(0, 7);
                for (int i = 0; i <= line_len + 1; i++) begin
                    if (burst_left == 0) begin
                        idle_cycles($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8));
                        burst_left = $urandom_range(1, 24);
                    end
                    burst_left--;
                    sent++;
                    if (i < line_len) begin
                        send_byte(($urandom_range(0, 7) == 0) ? CR_BYTE : 8'($urandom));
                    end else if (i == line_len) begin
                        send_byte((ending == 0) ? CR_BYTE : LF_BYTE);
                    end else begin
                        send_byte((ending == 0) ? LF_BYTE : 8'($urandom));
                        if (ending != 1) begin
                            sent--;
                        end
                    end
                    if (i == line_len && ending > 1) begin
                        break;
                    end
                end
            end
        end
    endtask

    initial begin
        int waited;
        i_rst_n       = 1'b0;
        push          = 1'b0;
        pop           = 1'b0;
        i_in_byte     = 8'h00;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        rx_mode       = RX_STREAM;
        rx_phase      = '0;
        cap           = '0;
        in_discard    = 1'b0;
        cr_held       = 1'b0;
        cur_len       = '0;
        n_cycles      = 0;
        n_errors      = 0;
        n_bytes_sent  = 0;
        n_results_checked = 0;
        n_cap_settings    = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_plain_lines();
        test_cr_handling();
        test_length_cap();
        test_cap_change_midline();
        test_random_traffic();

        idle_cycles(1);
        waited = 0;
        while (line_items_q.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (line_items_q.size() != 0) begin
            $error("%0d expected results never arrived", line_items_q.size());
            n_errors++;
        end

        $display("tb: %0d bytes pushed under %0d cap settings, %0d results compared",
                 n_bytes_sent, n_cap_settings, n_results_checked);
        $display("tb: %0d mismatches over %0d cycles", n_errors, n_cycles);
        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### line_splitter_with_length_cap_core.f
sv/lsc_pkg.sv
sv/lsc_front.sv
sv/lsc_queue.sv
sv/line_splitter_with_length_cap_core.sv
sim/tb_top.sv
